// ===== rtl/ehp_pkg.sv =====
// Shared types, constants and decode functions for the EBML element header parser.
package ehp_pkg;

  localparam int DATA_W      = 8;
  localparam int ID_W        = 64;
  localparam int SIZE_W      = 56;
  localparam int LEN_W       = 4;
  localparam int CFG_DATA_W  = 4;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ID_BYTES   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SIZE_BYTES = 1'b1;

  localparam logic [CFG_DATA_W-1:0] MAX_ID_BYTES_RST   = 4'd4;
  localparam logic [CFG_DATA_W-1:0] MAX_SIZE_BYTES_RST = 4'd8;

  localparam logic [DATA_W-1:0] LEAD_MARK = 8'h80;

  typedef logic [DATA_W-1:0] byte_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_ZERO_LEAD    = 3'd1,
    ST_ID_TOO_LONG  = 3'd2,
    ST_ID_RESERVED  = 3'd3,
    ST_SIZE_TOO_LONG = 3'd4,
    ST_UNKNOWN_SIZE = 3'd5
  } status_t;

  // vint length from the first byte: one plus its leading zero count, at most 8
  function automatic len_t lead_length(input byte_t b);
    len_t len;
    casez (b)
      8'b1???????: len = 4'd1;
      8'b01??????: len = 4'd2;
      8'b001?????: len = 4'd3;
      8'b0001????: len = 4'd4;
      8'b00001???: len = 4'd5;
      8'b000001??: len = 4'd6;
      8'b0000001?: len = 4'd7;
      default:     len = 4'd8;
    endcase
    return len;
  endfunction

  // all-ones mask over the 7*len value bits of a vint
  function automatic size_t value_ones(input len_t len);
    size_t m;
    case (len)
      4'd1:    m = size_t'({7{1'b1}});
      4'd2:    m = size_t'({14{1'b1}});
      4'd3:    m = size_t'({21{1'b1}});
      4'd4:    m = size_t'({28{1'b1}});
      4'd5:    m = size_t'({35{1'b1}});
      4'd6:    m = size_t'({42{1'b1}});
      4'd7:    m = size_t'({49{1'b1}});
      4'd8:    m = {SIZE_W{1'b1}};
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/ehp_if.sv =====
// Valid/ready channel interfaces for header bytes in and parsed headers out.
interface ehp_in_if;
  logic             valid;
  logic             ready;
  ehp_pkg::byte_t   data_byte;
  logic             restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface ehp_out_if;
  logic             valid;
  logic             ready;
  ehp_pkg::id_t     element_id;
  ehp_pkg::size_t   element_size;
  ehp_pkg::len_t    id_length;
  ehp_pkg::status_t status;

  modport source (output valid, output element_id, output element_size,
                  output id_length, output status, input ready);
  modport sink   (input valid, input element_id, input element_size,
                  input id_length, input status, output ready);
endinterface

// ===== rtl/ebml_element_header_parser_unit.sv =====
// EBML element header parser: one byte per transfer, ID and data size vints decoded.
// Output: a result appears in the output register in the cycle after the byte that completes
// or fails a header is transferred.
// Throughput: one byte per cycle; the input stalls only while a result waits in the
// output register and the sink is not ready.
// Reset: synchronous; limits return to 4 and 8, parser state clears, output empties.
module ebml_element_header_parser_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ehp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ehp_pkg::CFG_DATA_W-1:0]    cfg_data,
  ehp_in_if.sink                            in_ch,
  ehp_out_if.source                         out_ch
);
  import ehp_pkg::*;

  logic [CFG_DATA_W-1:0] max_id_bytes;
  logic [CFG_DATA_W-1:0] max_size_bytes;

  logic       in_size_field, in_size_field_next;
  logic [2:0] bytes_left, bytes_left_next;
  len_t       field_length, field_length_next;
  id_t        acc, acc_next;
  id_t        held_id, held_id_next;
  len_t       held_id_length, held_id_length_next;

  logic       out_valid;
  logic       accept;

  logic       cur_in_size;
  logic [2:0] cur_left;
  len_t       cur_len;
  id_t        cur_acc;
  byte_t      b;
  len_t       lead;
  logic       finish;
  id_t        fin_acc;
  len_t       fin_len;
  size_t      mask;
  size_t      id_val;

  logic       emit;
  id_t        res_id;
  size_t      res_size;
  len_t       res_len;
  status_t    res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_id_bytes   <= MAX_ID_BYTES_RST;
      max_size_bytes <= MAX_SIZE_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ID_BYTES:   max_id_bytes   <= cfg_data;
        CFG_MAX_SIZE_BYTES: max_size_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign lead        = lead_length(b);

  always_comb begin
    cur_in_size = in_size_field && !in_ch.restart;
    cur_left    = in_ch.restart ? 3'd0 : bytes_left;
    cur_len     = in_ch.restart ? '0 : field_length;
    cur_acc     = in_ch.restart ? '0 : acc;

    in_size_field_next  = cur_in_size;
    bytes_left_next     = cur_left;
    field_length_next   = cur_len;
    acc_next            = cur_acc;
    held_id_next        = held_id;
    held_id_length_next = held_id_length;

    emit       = 1'b0;
    res_id     = '0;
    res_size   = '0;
    res_len    = '0;
    res_status = ST_OK;
    finish     = 1'b0;
    fin_acc    = cur_acc;
    fin_len    = cur_len;

    if (cur_left != 3'd0) begin
      fin_acc         = {cur_acc[ID_W-DATA_W-1:0], b};
      acc_next        = fin_acc;
      bytes_left_next = cur_left - 3'd1;
      finish          = (cur_left == 3'd1);
    end else if (b == '0) begin
      emit       = 1'b1;
      res_status = ST_ZERO_LEAD;
      if (cur_in_size) begin
        res_id  = held_id;
        res_len = held_id_length;
      end
    end else if (!cur_in_size) begin
      if (lead > max_id_bytes) begin
        emit       = 1'b1;
        res_status = ST_ID_TOO_LONG;
        res_len    = lead;
      end else begin
        fin_acc           = {{(ID_W-DATA_W){1'b0}}, b};
        fin_len           = lead;
        acc_next          = fin_acc;
        field_length_next = lead;
        bytes_left_next   = lead[2:0] - 3'd1;
        finish            = (lead == 4'd1);
      end
    end else begin
      if (lead > max_size_bytes) begin
        emit       = 1'b1;
        res_status = ST_SIZE_TOO_LONG;
        res_id     = held_id;
        res_len    = held_id_length;
      end else begin
        fin_acc           = {{(ID_W-DATA_W){1'b0}}, b ^ (LEAD_MARK >> (lead - 4'd1))};
        fin_len           = lead;
        acc_next          = fin_acc;
        field_length_next = lead;
        bytes_left_next   = lead[2:0] - 3'd1;
        finish            = (lead == 4'd1);
      end
    end

    mask   = value_ones(fin_len);
    id_val = fin_acc[SIZE_W-1:0] & mask;

    if (finish) begin
      if (!cur_in_size) begin
        if (id_val == '0 || id_val == mask) begin
          emit       = 1'b1;
          res_status = ST_ID_RESERVED;
          res_id     = fin_acc;
          res_len    = fin_len;
        end else begin
          held_id_next        = fin_acc;
          held_id_length_next = fin_len;
          in_size_field_next  = 1'b1;
          bytes_left_next     = 3'd0;
          field_length_next   = '0;
          acc_next            = '0;
        end
      end else begin
        emit       = 1'b1;
        res_id     = held_id;
        res_len    = held_id_length;
        res_size   = fin_acc[SIZE_W-1:0];
        res_status = (fin_acc == {{(ID_W-SIZE_W){1'b0}}, mask}) ? ST_UNKNOWN_SIZE : ST_OK;
      end
    end

    if (emit) begin
      in_size_field_next = 1'b0;
      bytes_left_next    = 3'd0;
      field_length_next  = '0;
      acc_next           = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_size_field  <= 1'b0;
      bytes_left     <= 3'd0;
      field_length   <= '0;
      acc            <= '0;
      held_id        <= '0;
      held_id_length <= '0;
    end else if (accept) begin
      in_size_field  <= in_size_field_next;
      bytes_left     <= bytes_left_next;
      field_length   <= field_length_next;
      acc            <= acc_next;
      held_id        <= held_id_next;
      held_id_length <= held_id_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_ch.element_id   <= res_id;
      out_ch.element_size <= res_size;
      out_ch.id_length    <= res_len;
      out_ch.status       <= res_status;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

// ===== rtl/ehp_checker.sv =====
// Port-level assertions for the EBML element header parser, bound to the top level.
module ehp_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input ehp_pkg::id_t     element_id,
  input ehp_pkg::size_t   element_size,
  input ehp_pkg::len_t    id_length,
  input ehp_pkg::status_t status
);
  import ehp_pkg::*;

  a_out_empty_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(element_id) && $stable(status))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_ok_has_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> id_length != 4'd0 && id_length <= 4'd8 && element_id != '0)
    else $error("good header without a valid ID");

  a_zero_lead_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ZERO_LEAD || status == ST_ID_TOO_LONG ||
                  status == ST_SIZE_TOO_LONG) |-> element_size == '0)
    else $error("failed header carries a size");

endmodule

bind ebml_element_header_parser_unit ehp_checker u_ehp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .element_id   (out_ch.element_id),
  .element_size (out_ch.element_size),
  .id_length    (out_ch.id_length),
  .status       (out_ch.status)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the EBML element header parser: byte stream in, predicted headers checked out.
module tb;
  import ehp_pkg::*;

  typedef struct {
    id_t     id;
    size_t   size;
    len_t    idlen;
    status_t st;
  } header_t;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  localparam int   PHASES = 7;
  localparam int   PHASE_BYTES = 216;
  localparam len_t ID_LIMITS   [PHASES] = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd2, 4'd8};
  localparam len_t SIZE_LIMITS [PHASES] = '{4'd8, 4'd1, 4'd5, 4'd8, 4'd0, 4'd12, 4'd4};

  // Tracks the parser state and the headers it still owes.
  class header_predictor;
    len_t        id_limit;
    len_t        size_limit;
    bit          in_size;
    int          pending_bytes;
    len_t        flen;
    logic [63:0] acc;
    id_t         held_id;
    len_t        held_len;
    header_t     due[$];
    int          errors;

    function new();
      id_limit      = MAX_ID_BYTES_RST;
      size_limit    = MAX_SIZE_BYTES_RST;
      in_size       = 1'b0;
      pending_bytes = 0;
      flen          = '0;
      acc           = '0;
      held_id       = '0;
      held_len      = '0;
      errors        = 0;
    endfunction

    function logic [63:0] ones(len_t n);
      return (64'd1 << (7 * n)) - 64'd1;
    endfunction

    function len_t lead_len(byte_t b);
      len_t n;
      n = 4'd1;
      while (!b[7] && n < 4'd8) begin
        b = b << 1;
        n++;
      end
      return n;
    endfunction

    function void emit(id_t id, size_t sz, len_t n, status_t st);
      header_t h;
      h.id    = id;
      h.size  = sz;
      h.idlen = n;
      h.st    = st;
      due.push_back(h);
      in_size       = 1'b0;
      pending_bytes = 0;
      flen          = '0;
      acc           = '0;
    endfunction

    function void close_field();
      logic [63:0] v;
      if (!in_size) begin
        v = acc & ones(flen);
        if (v == '0 || v == ones(flen)) begin
          emit(acc, '0, flen, ST_ID_RESERVED);
        end else begin
          held_id       = acc;
          held_len      = flen;
          in_size       = 1'b1;
          pending_bytes = 0;
          flen          = '0;
          acc           = '0;
        end
      end else if (acc == ones(flen)) begin
        emit(held_id, acc[55:0], held_len, ST_UNKNOWN_SIZE);
      end else begin
        emit(held_id, acc[55:0], held_len, ST_OK);
      end
    endfunction

    function void take_byte(byte_t b, logic rs);
      len_t n;
      if (rs) begin
        in_size       = 1'b0;
        pending_bytes = 0;
        flen          = '0;
        acc           = '0;
      end
      if (pending_bytes != 0) begin
        acc = {acc[55:0], b};
        pending_bytes--;
        if (pending_bytes == 0) close_field();
        return;
      end
      if (b == 8'h00) begin
        if (in_size) emit(held_id, '0, held_len, ST_ZERO_LEAD);
        else emit('0, '0, '0, ST_ZERO_LEAD);
        return;
      end
      n = lead_len(b);
      if (!in_size) begin
        if (n > id_limit) begin
          emit('0, '0, n, ST_ID_TOO_LONG);
          return;
        end
        acc = 64'(b);
      end else begin
        if (n > size_limit) begin
          emit(held_id, '0, held_len, ST_SIZE_TOO_LONG);
          return;
        end
        acc = 64'(b ^ (LEAD_MARK >> (n - 1)));
      end
      flen          = n;
      pending_bytes = n - 1;
      if (pending_bytes == 0) close_field();
    endfunction

    function void match_header(id_t id, size_t sz, len_t n, status_t st);
      header_t h;
      if (due.size() == 0) begin
        $error("unexpected header: element_id %h element_size %h id_length %0d status %0d",
               id, sz, n, st);
        errors++;
        return;
      end
      h = due.pop_front();
      if (h.id !== id) begin
        $error("element_id expected %h actual %h", h.id, id);
        errors++;
      end
      if (h.size !== sz) begin
        $error("element_size expected %h actual %h", h.size, sz);
        errors++;
      end
      if (h.idlen !== n) begin
        $error("id_length expected %0d actual %0d", h.idlen, n);
        errors++;
      end
      if (h.st !== st) begin
        $error("status expected %0d actual %0d", h.st, st);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  bit                     quiet = 1'b0;
  int                     sent = 0;
  header_predictor        pred;

  ehp_in_if  in_ch ();
  ehp_out_if out_ch ();

  ebml_element_header_parser_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int send_gap();
    if (quiet || $urandom_range(0, 3) != 0) return 0;
    return gap_len();
  endfunction

  function automatic fill_t pick_fill();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return FILL_ZERO;
    if (r == 1) return FILL_ONES;
    return FILL_RANDOM;
  endfunction

  function automatic int pick_len(input len_t limit);
    int top;
    top = (limit == 4'd0 || limit > 4'd8) ? 8 : int'(limit);
    if ($urandom_range(0, 7) == 0) return $urandom_range(1, 8);
    return $urandom_range(1, top);
  endfunction

  function automatic byte_t fill_byte(input fill_t fill);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      default:   return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic byte_t vint_lead(input int n, input fill_t fill);
    byte_t mark;
    byte_t mask;
    mark = LEAD_MARK >> (n - 1);
    mask = mark - 8'd1;
    case (fill)
      FILL_ZERO: return mark;
      FILL_ONES: return mark | mask;
      default:   return mark | (fill_byte(FILL_RANDOM) & mask);
    endcase
  endfunction

  // Called just after a falling edge; returns just after the falling edge following the transfer.
  task automatic send_byte(input byte_t b, input logic rs);
    int gap;
    gap = send_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.data_byte = b;
    in_ch.restart   = rs;
    do @(posedge clk); while (!in_ch.ready);
    pred.take_byte(b, rs);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_vint(input int n, input fill_t fill, input logic rs, input int upto);
    send_byte(vint_lead(n, fill), rs);
    for (int i = 1; i < n && i < upto; i++) send_byte(fill_byte(fill), 1'b0);
  endtask

  task automatic set_limits(input len_t id_max, input len_t size_max);
    in_ch.valid = 1'b0;
    while (pred.due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_MAX_ID_BYTES;
    cfg_data  = id_max;
    @(negedge clk);
    cfg_index = CFG_MAX_SIZE_BYTES;
    cfg_data  = size_max;
    @(negedge clk);
    cfg_we = 1'b0;
    pred.id_limit   = id_max;
    pred.size_limit = size_max;
  endtask

  task automatic random_phase(input int quota);
    int start;
    int pick;
    int idn;
    int sn;
    start = sent;
    while (sent - start < quota) begin
      pick = $urandom_range(0, 99);
      idn  = pick_len(pred.id_limit);
      sn   = pick_len(pred.size_limit);
      if (pick < 75) begin
        send_vint(idn, pick_fill(), $urandom_range(0, 9) == 0, 8);
        send_vint(sn, pick_fill(), 1'b0, 8);
      end else if (pick < 88) begin
        // a header, possibly cut short, then a fresh one marked as a restart
        if ($urandom_range(0, 1) == 0) begin
          send_vint(idn, FILL_RANDOM, 1'b0, $urandom_range(1, idn));
        end else begin
          send_vint(idn, FILL_RANDOM, 1'b0, 8);
          send_vint(sn, FILL_RANDOM, 1'b0, $urandom_range(1, sn));
        end
        send_vint(pick_len(pred.id_limit), pick_fill(), 1'b1, 8);
        send_vint(pick_len(pred.size_limit), pick_fill(), 1'b0, 8);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(fill_byte(FILL_RANDOM), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      pred.match_header(out_ch.element_id, out_ch.element_size, out_ch.id_length,
                        out_ch.status);
  end

  initial begin
    pred            = new();
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = CFG_MAX_ID_BYTES;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.restart   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset limits: id 4, size 8
    send_byte(8'h81, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h1A, 1'b0);
    send_byte(8'h45, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hA3, 1'b0);
    send_byte(8'h84, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h86, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h86, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h81, 1'b1);
    send_byte(8'h81, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      set_limits(ID_LIMITS[p], SIZE_LIMITS[p]);
      quiet = (p == 2 || p == 5);
      random_phase(PHASE_BYTES);
    end
    quiet = 1'b0;
    set_limits(len_t'($urandom_range(0, 15)), len_t'($urandom_range(0, 15)));
    random_phase(PHASE_BYTES / 2);

    in_ch.valid = 1'b0;
    while (pred.due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pred.errors == 0) begin
      $display("ebml_element_header_parser_unit verification clean");
    end else begin
      $display("ebml_element_header_parser_unit verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("ebml_element_header_parser_unit verification failed");
    $finish;
  end

endmodule
